>>> rtl/lottery_scheduler_defines.svh
// Assertion macros shared by the lottery scheduler RTL.
// Files that check their own logic pull this in; it depends on nothing else.
`ifndef LOTTERY_SCHEDULER_DEFINES_SVH
`define LOTTERY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define LTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define LTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lts_pkg.sv
// Shared constants, codes and payload types of the lottery scheduler.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none

package lts_pkg;

  localparam int MAX_JOBS    = 16;
  localparam int IDX_W       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W       = $clog2(MAX_JOBS + 1);
  localparam int WEIGHT_W    = 4;
  localparam int TOTAL_W     = $clog2(((1 << WEIGHT_W) - 1) * MAX_JOBS + 1);
  localparam int TAG_W       = 8;
  localparam int DUR_W       = 16;
  localparam int RND_W       = 16;
  localparam int PRIO_W      = 2;
  localparam int WAIT_W      = 5;
  localparam int BIT_W       = $clog2(RND_W);
  localparam int CFG_IDX_W   = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LOW    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_NORMAL = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_HIGH   = CFG_IDX_W'(2);

  // Input action codes
  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  // Priority codes
  localparam logic [PRIO_W-1:0] PRIO_LOW    = PRIO_W'(0);
  localparam logic [PRIO_W-1:0] PRIO_NORMAL = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] PRIO_HIGH   = PRIO_W'(2);

  localparam logic [WEIGHT_W-1:0] WEIGHT_LOW_RST    = WEIGHT_W'(1);
  localparam logic [WEIGHT_W-1:0] WEIGHT_NORMAL_RST = WEIGHT_W'(2);
  localparam logic [WEIGHT_W-1:0] WEIGHT_HIGH_RST   = WEIGHT_W'(3);

  typedef enum logic [1:0] {
    OP_ARRIVE = 2'd0,
    OP_TICK   = 2'd1,
    OP_DROP   = 2'd2
  } op_e;

  typedef struct packed {
    logic              action;
    logic [TAG_W-1:0]  proc_id;
    logic [PRIO_W-1:0] priority_req;
    logic [DUR_W-1:0]  duration;
    logic [RND_W-1:0]  random_value;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  winner_id;
    logic              idle;
    logic              finished;
    logic              rejected;
    logic [WAIT_W-1:0] waiting_count;
  } out_item_t;

  typedef struct packed {
    op_e                 op;
    logic [TAG_W-1:0]    tag;
    logic [WEIGHT_W-1:0] tickets;
    logic [DUR_W-1:0]    duration;
    logic [RND_W-1:0]    draw;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/lts_front.sv
// Front end: holds the weight registers, accepts items and turns them into commands.
// Depends on lts_pkg.
`default_nettype none

module lts_front import lts_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WEIGHT_W-1:0]  cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_item_i,
  input  wire logic                 q_full_i,
  output logic                      push_o,
  output cmd_t                      cmd_o
);

  logic [WEIGHT_W-1:0] w_low_q, w_normal_q, w_high_q;
  logic                cmd_valid_q;
  cmd_t                cmd_q, cmd_d;
  logic [WEIGHT_W-1:0] weight;
  logic                accept;

  assign push_o     = cmd_valid_q && !q_full_i;
  assign in_stall_o = cmd_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd_o      = cmd_q;

  always_comb begin
    case (in_item_i.priority_req)
      PRIO_LOW:    weight = w_low_q;
      PRIO_NORMAL: weight = w_normal_q;
      PRIO_HIGH:   weight = w_high_q;
      default:     weight = '0;
    endcase
  end

  always_comb begin
    cmd_d.tag      = in_item_i.proc_id;
    cmd_d.tickets  = weight;
    cmd_d.duration = in_item_i.duration;
    cmd_d.draw     = in_item_i.random_value;
    if (in_item_i.action == ACT_TICK) begin
      cmd_d.op = OP_TICK;
    end else if (in_item_i.duration == '0) begin
      cmd_d.op = OP_DROP;
    end else begin
      cmd_d.op = OP_ARRIVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_low_q    <= WEIGHT_LOW_RST;
      w_normal_q <= WEIGHT_NORMAL_RST;
      w_high_q   <= WEIGHT_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WEIGHT_LOW:    w_low_q    <= cfg_data_i;
        CFG_WEIGHT_NORMAL: w_normal_q <= cfg_data_i;
        CFG_WEIGHT_HIGH:   w_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (accept) begin
      cmd_valid_q <= 1'b1;
    end else if (push_o) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lts_fifo.sv
// Short command queue between the front end and the scheduling engine.
// Depends on lts_pkg and the assertion macros.
`default_nettype none
`include "lottery_scheduler_defines.svh"

module lts_fifo import lts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  `LTS_ASSERT_NOW(a_fifo_no_overflow, push_i && !pop_i, !full_o, "lts_fifo: push into full queue")
  `LTS_ASSERT_NOW(a_fifo_no_underflow, pop_i, cnt_q != '0, "lts_fifo: pop from empty queue")
  `LTS_ASSERT_NOW(a_fifo_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH), "lts_fifo: count past depth")

endmodule

`default_nettype wire

>>> rtl/lts_back.sv
// Scheduling engine: job table, serial modulo of the draw, ordered ticket walk,
// entry removal and the output register. Depends on lts_pkg and the assertion macros.
`default_nettype none
`include "lottery_scheduler_defines.svh"

module lts_back import lts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire cmd_t q_cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_WALK = 5'b00100,
    S_UPD  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Job table, kept in arrival order
  logic [TAG_W-1:0]    tag_q  [MAX_JOBS];
  logic [DUR_W-1:0]    left_q [MAX_JOBS];
  logic [WEIGHT_W-1:0] tix_q  [MAX_JOBS];

  logic [CNT_W-1:0]   count_q, count_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [RND_W-1:0]   div_q, div_d;
  logic [TOTAL_W-1:0] mod_q, mod_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [TOTAL_W-1:0] upper_q, upper_d;
  out_item_t          res_q, res_d;
  out_item_t          out_q;
  logic               out_valid_q;

  logic                wr_arrive, wr_dec, wr_drop, out_load, out_free;
  logic [TOTAL_W:0]    trial;
  logic [TOTAL_W-1:0]  up_next;
  logic [TAG_W-1:0]    tag_rd;
  logic [DUR_W-1:0]    left_rd, left_dec;
  logic [WEIGHT_W-1:0] tix_rd;

  assign tag_rd   = tag_q[idx_q];
  assign left_rd  = left_q[idx_q];
  assign tix_rd   = tix_q[idx_q];
  assign left_dec = left_rd - 1'b1;
  assign trial    = {mod_q, div_q[RND_W-1]};
  assign up_next  = upper_q + TOTAL_W'(tix_rd);
  assign out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    total_d   = total_q;
    div_d     = div_q;
    mod_d     = mod_q;
    bit_d     = bit_q;
    idx_d     = idx_q;
    upper_d   = upper_q;
    res_d     = res_q;
    pop_o     = 1'b0;
    wr_arrive = 1'b0;
    wr_dec    = 1'b0;
    wr_drop   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o               = 1'b1;
          res_d               = '0;
          res_d.waiting_count = WAIT_W'(count_q);
          state_d             = S_DONE;
          case (q_cmd_i.op)
            OP_ARRIVE: begin
              if (count_q >= CNT_W'(MAX_JOBS)) begin
                res_d.rejected = 1'b1;
              end else begin
                wr_arrive           = 1'b1;
                count_d             = count_q + 1'b1;
                total_d             = total_q + TOTAL_W'(q_cmd_i.tickets);
                res_d.waiting_count = WAIT_W'(count_d);
              end
            end
            OP_TICK: begin
              if (count_q == '0 || total_q == '0) begin
                res_d.idle = 1'b1;
              end else begin
                div_d   = q_cmd_i.draw;
                mod_d   = '0;
                bit_d   = '0;
                state_d = S_DIV;
              end
            end
            default: begin
              res_d.rejected = 1'b1;
            end
          endcase
        end
      end
      S_DIV: begin
        // one quotient bit a cycle; only the remainder is kept
        if (trial >= {1'b0, total_q}) begin
          mod_d = TOTAL_W'(trial - {1'b0, total_q});
        end else begin
          mod_d = trial[TOTAL_W-1:0];
        end
        div_d = div_q << 1;
        bit_d = bit_q + 1'b1;
        if (bit_q == BIT_W'(RND_W - 1)) begin
          idx_d   = '0;
          upper_d = '0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (mod_q < up_next) begin
          state_d = S_UPD;
        end else if (CNT_W'(idx_q) + CNT_W'(1) >= count_q) begin
          res_d.idle = 1'b1;
          state_d    = S_DONE;
        end else begin
          upper_d = up_next;
          idx_d   = idx_q + 1'b1;
        end
      end
      S_UPD: begin
        res_d.winner_id = tag_rd;
        if (left_dec == '0) begin
          wr_drop             = 1'b1;
          total_d             = total_q - TOTAL_W'(tix_rd);
          count_d             = count_q - 1'b1;
          res_d.finished      = 1'b1;
          res_d.waiting_count = WAIT_W'(count_d);
        end else begin
          wr_dec = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    div_q   <= div_d;
    mod_q   <= mod_d;
    bit_q   <= bit_d;
    idx_q   <= idx_d;
    upper_q <= upper_d;
    res_q   <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Table writes: append, decrement in place, or close the gap of a finished job
  always_ff @(posedge clk_i) begin
    if (wr_arrive) begin
      tag_q[count_q[IDX_W-1:0]]  <= q_cmd_i.tag;
      left_q[count_q[IDX_W-1:0]] <= q_cmd_i.duration;
      tix_q[count_q[IDX_W-1:0]]  <= q_cmd_i.tickets;
    end
    if (wr_dec) begin
      left_q[idx_q] <= left_dec;
    end
    if (wr_drop) begin
      for (int j = 0; j < MAX_JOBS - 1; j++) begin
        if (IDX_W'(j) >= idx_q && CNT_W'(j + 1) < count_q) begin
          tag_q[j]  <= tag_q[j + 1];
          left_q[j] <= left_q[j + 1];
          tix_q[j]  <= tix_q[j + 1];
        end
      end
    end
  end

  `LTS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_JOBS), "lts_back: job count past table size")
  `LTS_ASSERT_NOW(a_empty_no_tickets, count_q == '0, total_q == '0, "lts_back: tickets left in empty table")
  `LTS_ASSERT_NOW(a_draw_in_range, state_q == S_WALK, mod_q < total_q, "lts_back: reduced draw not below total")

endmodule

`default_nettype wire

>>> rtl/lottery_scheduler.sv
// Channel   Direction  Payload     Handshake
// in        input      in_item_t   in_valid_i / in_stall_o
// out       output     out_item_t  out_valid_o / out_stall_i
// cfg       input      weights     cfg_we_i (write only)
//
// An arrival, or a tick that finds no job, goes from the front register through the queue
// and the engine to the output register. A scheduled tick adds a bit-serial modulo over
// the 16 draw bits, a walk of 1 to 16 table entries, and then the table update.
// Reset clears the job count, ticket total and queues; weights return to 1, 2, 3.
// A two-entry queue lets the front accept items while the engine works or the
// output register is stalled.
// Top level of the lottery scheduler; depends on lts_pkg, lts_front, lts_fifo, lts_back.
`default_nettype none

module lottery_scheduler import lts_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WEIGHT_W-1:0]  cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_item_o
);

  logic q_full, q_push, q_pop, q_valid;
  cmd_t f_cmd, q_cmd;

  lts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (f_cmd)
  );

  lts_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (f_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  lts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the lottery scheduler: directed rows, then random
// traffic over several weight settings, checked against an in-bench predictor.
// Depends on lts_pkg and the lottery_scheduler RTL.
module testbench import lts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 190;
  localparam int STUCK_BUDGET = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = CFG_IDX_W'(3);
  localparam logic [PRIO_W-1:0]    PRIO_UNDEF = PRIO_W'(3);

  typedef struct {
    logic              action;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic [DUR_W-1:0]  dur;
    logic [RND_W-1:0]  rnd;
    int                reps;
    bit                typed;
    out_item_t         want;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [WEIGHT_W-1:0]  cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;

  // Scheduler image kept by the predictor
  logic [WEIGHT_W-1:0] weight_reg [3] = '{WEIGHT_LOW_RST, WEIGHT_NORMAL_RST, WEIGHT_HIGH_RST};
  logic [TAG_W-1:0]    job_id_m [MAX_JOBS];
  logic [DUR_W-1:0]    job_left [MAX_JOBS];
  logic [WEIGHT_W-1:0] job_wt [MAX_JOBS];
  int unsigned         jobs_held = 0;
  int unsigned         tickets_all = 0;
  int                  stuck_jobs = 0;

  out_item_t expected_results [$];
  plan_row_t plan [$];

  int  errors = 0;
  int  results_seen = 0;
  int  quiet_cycles = 0;
  int  n_arrive = 0, n_tick = 0, n_reject = 0, n_idle = 0, n_done = 0;
  int  burst_left = 0;
  int  stall_left = 0;
  bit  valid_up = 1'b0;
  out_item_t got_item, want_item;

  lottery_scheduler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [WEIGHT_W-1:0] weight_for(logic [PRIO_W-1:0] prio);
    case (prio)
      PRIO_LOW:    return weight_reg[CFG_WEIGHT_LOW];
      PRIO_NORMAL: return weight_reg[CFG_WEIGHT_NORMAL];
      PRIO_HIGH:   return weight_reg[CFG_WEIGHT_HIGH];
      default:     return '0;
    endcase
  endfunction

  function automatic out_item_t predict_schedule(in_item_t it);
    out_item_t           res;
    logic [WEIGHT_W-1:0] w;
    int unsigned         draw;
    int unsigned         upper;
    int unsigned         slot;
    res = '0;
    if (it.action == ACT_ARRIVE) begin
      n_arrive++;
      if (jobs_held >= MAX_JOBS || it.duration == '0) begin
        res.rejected = 1'b1;
        n_reject++;
      end else begin
        w = weight_for(it.priority_req);
        job_id_m[jobs_held] = it.proc_id;
        job_left[jobs_held] = it.duration;
        job_wt[jobs_held]   = w;
        jobs_held++;
        tickets_all += w;
        if (w == '0) stuck_jobs++;
      end
    end else begin
      n_tick++;
      if (jobs_held == 0 || tickets_all == 0) begin
        res.idle = 1'b1;
        n_idle++;
      end else begin
        draw  = it.random_value % tickets_all;
        upper = 0;
        slot  = jobs_held;
        // first entry whose ticket run covers the draw
        for (int i = 0; i < jobs_held; i++) begin
          upper += job_wt[i];
          if (slot == jobs_held && draw < upper) slot = i;
        end
        res.winner_id = job_id_m[slot];
        job_left[slot] = job_left[slot] - 1'b1;
        if (job_left[slot] == '0) begin
          tickets_all -= job_wt[slot];
          for (int i = slot; i + 1 < jobs_held; i++) begin
            job_id_m[i] = job_id_m[i + 1];
            job_left[i] = job_left[i + 1];
            job_wt[i]   = job_wt[i + 1];
          end
          jobs_held--;
          res.finished = 1'b1;
          n_done++;
        end
      end
    end
    res.waiting_count = WAIT_W'(jobs_held);
    return res;
  endfunction

  function automatic out_item_t outcome(logic [TAG_W-1:0] w, bit idl, bit fin, bit rej,
                                        int cnt);
    out_item_t res;
    res.winner_id     = w;
    res.idle          = idl;
    res.finished      = fin;
    res.rejected      = rej;
    res.waiting_count = WAIT_W'(cnt);
    return res;
  endfunction

  function automatic void add_row(logic action, logic [TAG_W-1:0] tag,
                                  logic [PRIO_W-1:0] prio, logic [DUR_W-1:0] dur,
                                  logic [RND_W-1:0] rnd, int reps, bit typed,
                                  out_item_t want);
    plan_row_t row;
    row.action = action;
    row.tag    = tag;
    row.prio   = prio;
    row.dur    = dur;
    row.rnd    = rnd;
    row.reps   = reps;
    row.typed  = typed;
    row.want   = want;
    plan.push_back(row);
  endfunction

  function automatic in_item_t random_job_item(int arrive_pct);
    in_item_t it;
    it.proc_id      = TAG_W'($urandom_range(0, 255));
    it.random_value = RND_W'($urandom_range(0, 65535));
    it.priority_req = ($urandom_range(0, 9) == 0) ? PRIO_UNDEF
                                                   : PRIO_W'($urandom_range(0, 2));
    it.action = ($urandom_range(1, 100) <= arrive_pct) ? ACT_ARRIVE : ACT_TICK;
    if (it.action == ACT_TICK || jobs_held >= MAX_JOBS)
      it.duration = DUR_W'($urandom_range(0, 65535));
    else if ($urandom_range(0, 19) == 0)
      it.duration = '0;
    else
      it.duration = DUR_W'($urandom_range(1, 6));
    // zero-ticket jobs never leave; cap them so the table keeps turning over
    if (it.action == ACT_ARRIVE && it.duration != '0 && jobs_held < MAX_JOBS &&
        weight_for(it.priority_req) == '0 && stuck_jobs >= STUCK_BUDGET) begin
      if (weight_reg[CFG_WEIGHT_HIGH] != '0)        it.priority_req = PRIO_HIGH;
      else if (weight_reg[CFG_WEIGHT_NORMAL] != '0) it.priority_req = PRIO_NORMAL;
      else if (weight_reg[CFG_WEIGHT_LOW] != '0)    it.priority_req = PRIO_LOW;
      else                                          it.duration = '0;
    end
    return it;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    $display("[%0t] error: %s", $time, msg);
  endtask

  // Drive one item, hold it until taken, then record what it should produce.
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    valid_up = 1'b1;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    predicted = predict_schedule(it);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic settle();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_weight(input logic [CFG_IDX_W-1:0] idx,
                              input logic [WEIGHT_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx <= CFG_WEIGHT_HIGH) weight_reg[idx] = val;
  endtask

  // Receiver: stall runs, free runs, and now and then a long free stretch.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_left  <= ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 6);
    end
  end

  // Sample handshakes mid-cycle, where every input and output is settled.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got_item = out_item_o;
        results_seen++;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          want_item = expected_results.pop_front();
          if (got_item.winner_id !== want_item.winner_id)
            flag_error($sformatf("result %0d winner_id %0h, expected %0h", results_seen,
                                 got_item.winner_id, want_item.winner_id));
          if (got_item.idle !== want_item.idle)
            flag_error($sformatf("result %0d idle %0b, expected %0b", results_seen,
                                 got_item.idle, want_item.idle));
          if (got_item.finished !== want_item.finished)
            flag_error($sformatf("result %0d finished %0b, expected %0b", results_seen,
                                 got_item.finished, want_item.finished));
          if (got_item.rejected !== want_item.rejected)
            flag_error($sformatf("result %0d rejected %0b, expected %0b", results_seen,
                                 got_item.rejected, want_item.rejected));
          if (got_item.waiting_count !== want_item.waiting_count)
            flag_error($sformatf("result %0d waiting_count %0d, expected %0d", results_seen,
                                 got_item.waiting_count, want_item.waiting_count));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] timeout: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    in_item_t it;
    out_item_t none;
    int arrive_pct;
    none = '0;

    // action, tag, prio, duration, random, repeats, typed, expected
    add_row(ACT_TICK,   8'h00, PRIO_LOW,    16'h0000, 16'h1234, 1, 1,
            outcome(8'h00, 1, 0, 0, 0));                     // empty table
    add_row(ACT_ARRIVE, 8'hFF, PRIO_HIGH,   16'h0000, 16'h0000, 1, 1,
            outcome(8'h00, 0, 0, 1, 0));                     // zero duration
    add_row(ACT_ARRIVE, 8'h00, PRIO_LOW,    16'h0001, 16'hFFFF, 1, 1,
            outcome(8'h00, 0, 0, 0, 1));
    add_row(ACT_TICK,   8'hFF, PRIO_HIGH,   16'hFFFF, 16'hFFFF, 1, 1,
            outcome(8'h00, 0, 1, 0, 0));                     // lone job finishes
    add_row(ACT_ARRIVE, 8'hA5, PRIO_UNDEF,  16'h0005, 16'h0000, 1, 1,
            outcome(8'h00, 0, 0, 0, 1));                     // undefined priority
    add_row(ACT_TICK,   8'h00, PRIO_LOW,    16'h0000, 16'h0007, 1, 1,
            outcome(8'h00, 1, 0, 0, 1));                     // zero ticket total
    add_row(ACT_ARRIVE, 8'h5A, PRIO_NORMAL, 16'hFFFF, 16'h0000, 1, 1,
            outcome(8'h00, 0, 0, 0, 2));
    add_row(ACT_ARRIVE, 8'h11, PRIO_HIGH,   16'h0001, 16'h0000, 1, 1,
            outcome(8'h00, 0, 0, 0, 3));
    add_row(ACT_TICK,   8'h00, PRIO_LOW,    16'h0000, 16'h0000, 1, 0, none);
    add_row(ACT_TICK,   8'h00, PRIO_LOW,    16'h0000, 16'h0004, 1, 0, none);
    add_row(ACT_ARRIVE, 8'h20, PRIO_LOW,    16'h0003, 16'h0000, 14, 0, none);  // fill
    add_row(ACT_ARRIVE, 8'hFF, PRIO_HIGH,   16'hFFFF, 16'hFFFF, 1, 1,
            outcome(8'h00, 0, 0, 1, 16));                    // full table
    add_row(ACT_TICK,   8'h00, PRIO_LOW,    16'h0000, 16'hFFFF, 1, 0, none);
    add_row(ACT_TICK,   8'h00, PRIO_LOW,    16'h0000, 16'h8000, 1, 0, none);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        it.action       = plan[r].action;
        it.proc_id      = plan[r].tag + TAG_W'(k);
        it.priority_req = plan[r].prio;
        it.duration     = plan[r].dur;
        it.random_value = plan[r].rnd;
        push_item(it, plan[r].typed, plan[r].want);
        pace();
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          write_weight(CFG_WEIGHT_LOW, 4'd0);
          write_weight(CFG_WEIGHT_NORMAL, 4'd15);
          write_weight(CFG_WEIGHT_HIGH, 4'd15);
          write_weight(CFG_SPARE, 4'd9);            // no such register: dropped
          arrive_pct = 45;
        end
        1: begin
          write_weight(CFG_WEIGHT_LOW, 4'd15);
          write_weight(CFG_WEIGHT_NORMAL, 4'd15);
          write_weight(CFG_WEIGHT_HIGH, 4'd15);
          arrive_pct = 80;
        end
        2: begin
          write_weight(CFG_WEIGHT_LOW, WEIGHT_LOW_RST);
          write_weight(CFG_WEIGHT_NORMAL, WEIGHT_NORMAL_RST);
          write_weight(CFG_WEIGHT_HIGH, WEIGHT_HIGH_RST);
          arrive_pct = 55;
        end
        4: begin
          write_weight(CFG_WEIGHT_LOW, 4'd0);
          write_weight(CFG_WEIGHT_NORMAL, 4'd0);
          write_weight(CFG_WEIGHT_HIGH, 4'd1);
          arrive_pct = 35;
        end
        default: begin
          write_weight(CFG_WEIGHT_LOW, WEIGHT_W'($urandom_range(0, 15)));
          write_weight(CFG_WEIGHT_NORMAL, WEIGHT_W'($urandom_range(0, 15)));
          write_weight(CFG_WEIGHT_HIGH, WEIGHT_W'($urandom_range(1, 15)));
          write_weight(CFG_SPARE, WEIGHT_W'($urandom_range(0, 15)));
          arrive_pct = (p == 3) ? 50 : 65;
        end
      endcase
      cfg_we_i <= 1'b0;
      repeat (PHASE_ITEMS) begin
        push_item(random_job_item(arrive_pct), 1'b0, none);
        pace();
      end
    end

    settle();
    $display("Checked %0d results: %0d arrivals (%0d rejected), %0d ticks (%0d idle)",
             results_seen, n_arrive, n_reject, n_tick, n_idle);
    $display("%0d jobs ran to completion across %0d weight settings, zero to fifteen",
             n_done, PHASES + 1);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> lottery_scheduler.f
+incdir+rtl
rtl/lts_pkg.sv
rtl/lts_front.sv
rtl/lts_fifo.sv
rtl/lts_back.sv
rtl/lottery_scheduler.sv
sim/testbench.sv
